FILE: hdl/rass_pkg.sv
package rass_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_WIDTH  = 64;

    localparam int IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W  = 9;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 8;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(8);
    localparam logic [CNT_W-1:0]    COUNT_FULL   = CNT_W'(STACK_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_RET_OK    = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_HALTED    = 3'd6
    } status_t;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [ADDR_WIDTH-1:0] wdata;
    } stack_cmd_t;

endpackage

FILE: hdl/rass_stack.sv
// Stack storage with a prefetched top entry: the read port always fetches
// the entry that will be on top after this cycle's push or pop.
module rass_stack (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rass_pkg::stack_cmd_t           cmd,
    output logic [rass_pkg::CNT_W-1:0]     count,
    output logic [rass_pkg::ADDR_WIDTH-1:0] top
);

    logic [rass_pkg::ADDR_WIDTH-1:0] mem [rass_pkg::STACK_DEPTH];
    logic [rass_pkg::CNT_W-1:0]      count_reg;
    logic [rass_pkg::CNT_W-1:0]      count_next;
    logic [rass_pkg::ADDR_WIDTH-1:0] top_reg;
    logic [rass_pkg::CNT_W-1:0]      rd_cnt;
    logic [rass_pkg::IDX_W-1:0]      rd_addr;
    logic [rass_pkg::IDX_W-1:0]      wr_addr;

    always_comb begin
        if (cmd.push) begin
            count_next = count_reg + rass_pkg::CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - rass_pkg::CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
        rd_cnt  = count_next - rass_pkg::CNT_W'(1);
        rd_addr = rd_cnt[rass_pkg::IDX_W-1:0];
        wr_addr = count_reg[rass_pkg::IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_addr] <= cmd.wdata;
        end
    end

    // A push puts the new entry on top: forward it past the memory.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            top_reg <= cmd.wdata;
        end else if (count_next != '0) begin
            top_reg <= mem[rd_addr];
        end
    end

    assign count = count_reg;
    assign top   = top_reg;

endmodule

FILE: hdl/return_address_shadow_stack.sv
// An accepted item goes to the input register, then to the result register once
// the latter is empty or being drained. Throughput: one item per cycle while the
// consumer does not stall; the stack memory read port prefetches the next top entry
// each cycle, so back-to-back pops run at full rate.
// Reset (synchronous, aresetn low): empties the stack, clears the halted
// flag and both pipeline stages, and sets max_return_offset to 8.
module return_address_shadow_stack (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Configuration: max_return_offset
    input  logic                               cfg_wr_en,
    input  logic [rass_pkg::OFFSET_W-1:0]      cfg_wr_data,

    // Event input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [rass_pkg::ADDR_WIDTH-1:0]    s_instr_addr,
    input  logic [rass_pkg::ADDR_WIDTH-1:0]    s_target_addr,
    input  logic                               s_excluded,

    // Result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rass_pkg::STATUS_W-1:0]      m_status,
    output logic [rass_pkg::ADDR_WIDTH-1:0]    m_expected_addr,
    output logic [rass_pkg::DEPTH_W-1:0]       m_stack_depth
);

    // Configuration register
    logic [rass_pkg::OFFSET_W-1:0] max_offset_reg;

    // Input stage
    logic                            in_valid_reg;
    logic                            opcode_reg;
    logic [rass_pkg::ADDR_WIDTH-1:0] instr_addr_reg;
    logic [rass_pkg::ADDR_WIDTH-1:0] target_addr_reg;
    logic                            excluded_reg;

    // Result stage
    logic                            out_valid_reg;
    rass_pkg::status_t               status_reg;
    rass_pkg::status_t               status_next;
    logic [rass_pkg::ADDR_WIDTH-1:0] expected_reg;
    logic [rass_pkg::ADDR_WIDTH-1:0] expected_next;
    logic [rass_pkg::CNT_W-1:0]      depth_reg;
    logic [rass_pkg::CNT_W-1:0]      depth_next;

    // Sticky violation flag
    logic                            halted_reg;
    logic                            halted_next;

    logic                            advance;
    rass_pkg::stack_cmd_t            cmd;
    logic [rass_pkg::CNT_W-1:0]      count;
    logic [rass_pkg::ADDR_WIDTH-1:0] top;
    logic [rass_pkg::ADDR_WIDTH-1:0] ret_dist;

    // Move an item from the input register to the result register whenever
    // the result register is empty or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_offset_reg <= rass_pkg::OFFSET_RESET;
        end else if (cfg_wr_en) begin
            max_offset_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Hold the payload until the item moves on
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg      <= s_opcode;
            instr_addr_reg  <= s_instr_addr;
            target_addr_reg <= s_target_addr;
            excluded_reg    <= s_excluded;
        end
    end

    // Decide the event. Priority: halted, excluded, then call / return.
    always_comb begin
        cmd           = '{push: 1'b0, pop: 1'b0, wdata: instr_addr_reg};
        status_next   = rass_pkg::ST_HALTED;
        expected_next = '0;
        depth_next    = count;
        halted_next   = halted_reg;
        ret_dist      = target_addr_reg - top;

        if (halted_reg) begin
            status_next = rass_pkg::ST_HALTED;
        end else if (excluded_reg) begin
            status_next = rass_pkg::ST_SKIPPED;
        end else if (!opcode_reg) begin
            if (count == rass_pkg::COUNT_FULL) begin
                status_next = rass_pkg::ST_OVERFLOW;
            end else begin
                cmd.push    = advance;
                status_next = rass_pkg::ST_PUSHED;
                depth_next  = count + rass_pkg::CNT_W'(1);
            end
        end else if (count == '0) begin
            status_next = rass_pkg::ST_UNDERFLOW;
        end else begin
            // Pop and check that the target lies within range past the call
            cmd.pop       = advance;
            expected_next = top;
            depth_next    = count - rass_pkg::CNT_W'(1);
            if (ret_dist <= rass_pkg::ADDR_WIDTH'(max_offset_reg)) begin
                status_next = rass_pkg::ST_RET_OK;
            end else begin
                status_next = rass_pkg::ST_MISMATCH;
                halted_next = 1'b1;
            end
        end
    end

    rass_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .count   (count),
        .top     (top)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg <= 1'b0;
        end else if (advance) begin
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result; hold it while the consumer stalls
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg   <= status_next;
            expected_reg <= expected_next;
            depth_reg    <= depth_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = status_reg;
    assign m_expected_addr = expected_reg;
    assign m_stack_depth   = rass_pkg::DEPTH_W'(depth_reg);

endmodule

FILE: hdl/rass_checker.sv
module rass_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [rass_pkg::STATUS_W-1:0]   m_status,
    input  logic [rass_pkg::ADDR_WIDTH-1:0] m_expected_addr,
    input  logic [rass_pkg::DEPTH_W-1:0]    m_stack_depth
);

    localparam logic [rass_pkg::DEPTH_W-1:0] FULL_DEPTH =
        rass_pkg::DEPTH_W'(rass_pkg::STACK_DEPTH);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
                                && $stable(m_expected_addr) && $stable(m_stack_depth))
        else $error("result changed while stalled");

    a_addr_only_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rass_pkg::ST_RET_OK && m_status != rass_pkg::ST_MISMATCH
        |-> m_expected_addr == '0)
        else $error("expected address set on a non-pop result");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rass_pkg::ST_OVERFLOW |-> m_stack_depth == FULL_DEPTH)
        else $error("overflow reported on a stack that is not full");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rass_pkg::ST_UNDERFLOW |-> m_stack_depth == '0)
        else $error("underflow reported on a stack that is not empty");

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rass_pkg::ST_PUSHED |-> m_stack_depth != '0)
        else $error("push left the stack empty");

endmodule

bind return_address_shadow_stack rass_checker u_rass_checker (.*);
